>>> hw/rtl/glls_pkg.sv
// ----------------------------------------------------------------------------
// glls_pkg
// shared types, widths and constants of the gaussian log-likelihood scorer
// ----------------------------------------------------------------------------
package glls_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_FEATURES_DEF = 64;

  // field widths
  localparam int OP_W     = 2;
  localparam int CL_W     = 4;
  localparam int FI_W     = 6;
  localparam int VAL_W    = 16;
  localparam int OFF_W    = 32;
  localparam int SCL_W    = 16;
  localparam int CFG_W    = 5;
  localparam int CIDX_W   = 4;
  localparam int SCORE_W  = 40;
  localparam int ACC_W    = 38;
  localparam int SQ_W     = 32;
  localparam int PROD_W   = ACC_W + SCL_W;
  localparam int PARAM_W  = OFF_W + SCL_W;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [ACC_W-1:0]   ACC_MAX   = {ACC_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // result queue
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_FIFO_AW    = 2;
  localparam int RES_FIFO_CW    = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_MEAN  = 2'd0,
    OP_LOAD_PARAM = 2'd1,
    OP_SCORE      = 2'd2
  } glls_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCORE,
    ST_DRAIN,
    ST_EMIT
  } glls_state_t;

  // per-cluster issue tag going into the datapaths
  typedef struct packed {
    logic vld;
    logic last;
    logic ok;
  } glls_issue_t;

  typedef struct packed {
    logic                      last;
    logic [CIDX_W-1:0]         idx;
    logic signed [SCORE_W-1:0] score;
  } glls_result_t;

endpackage

>>> hw/rtl/glls_ram.sv
// ----------------------------------------------------------------------------
// glls_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module glls_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/glls_accum.sv
// ----------------------------------------------------------------------------
// glls_accum
// squared-distance update pipeline: difference, square, saturating add
// ----------------------------------------------------------------------------
module glls_accum
  import glls_pkg::*;
#(
  parameter int CIW = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  glls_issue_t             iss,
  input  logic [CIW-1:0]          iss_idx,
  input  logic signed [VAL_W-1:0] x,
  input  logic [VAL_W-1:0]        mean_rd,
  input  logic [ACC_W-1:0]        acc_rd,
  output logic                    wr_en,
  output logic [CIW-1:0]          wr_idx,
  output logic [ACC_W-1:0]        wr_data,
  output logic                    busy
);

  logic                    p1_vld_r, p2_vld_r, p3_vld_r;
  logic [CIW-1:0]          p1_idx_r, p2_idx_r, p3_idx_r;
  logic                    p1_ok_r;
  logic signed [VAL_W:0]   p2_diff_r;
  logic [ACC_W-1:0]        p2_acc_r, p3_acc_r;
  logic [SQ_W-1:0]         p3_sq_r;

  logic signed [VAL_W:0]     diff;
  logic signed [2*VAL_W+1:0] sq_full;
  logic [ACC_W:0]            sum;

  // stage 1: ram data is here, form the difference
  assign diff = VAL_W'(0) + ({x[VAL_W-1], x} - {mean_rd[VAL_W-1], mean_rd});
  // stage 2: square fits 32 bits since |diff| < 2^16
  assign sq_full = p2_diff_r * p2_diff_r;
  // stage 3: saturating add
  assign sum = {1'b0, p3_acc_r} + {{(ACC_W+1-SQ_W){1'b0}}, p3_sq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= iss.vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_idx_r  <= iss_idx;
    p1_ok_r   <= iss.ok;
    p2_idx_r  <= p1_idx_r;
    p2_diff_r <= diff;
    p2_acc_r  <= p1_ok_r ? acc_rd : '0;
    p3_idx_r  <= p2_idx_r;
    p3_acc_r  <= p2_acc_r;
    p3_sq_r   <= sq_full[SQ_W-1:0];
  end

  assign wr_en   = p3_vld_r;
  assign wr_idx  = p3_idx_r;
  assign wr_data = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
  assign busy    = p1_vld_r | p2_vld_r | p3_vld_r;

endmodule

>>> hw/rtl/glls_emit.sv
// ----------------------------------------------------------------------------
// glls_emit
// score pipeline: scale multiply, round, subtract from offset, saturate, queue
// ----------------------------------------------------------------------------
module glls_emit
  import glls_pkg::*;
#(
  parameter int CIW = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  glls_issue_t        iss,
  input  logic [CIW-1:0]     iss_idx,
  input  logic [ACC_W-1:0]   acc_rd,
  input  logic [PARAM_W-1:0] param_rd,
  output logic               room,
  output logic               res_valid,
  input  logic               res_ready,
  output glls_result_t       res
);

  logic                    e1_vld_r, e2_vld_r;
  logic [CIW-1:0]          e1_idx_r, e2_idx_r;
  logic                    e1_last_r, e2_last_r, e1_ok_r;
  logic [PROD_W-1:0]       e2_prod_r;
  logic [OFF_W-1:0]        e2_off_r;

  glls_result_t            fifo_r [RES_FIFO_DEPTH];
  logic [RES_FIFO_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [RES_FIFO_CW-1:0]  cnt_r;

  logic [ACC_W-1:0]        acc_eff;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W:0]         rsum;
  logic [SCORE_W:0]        sdiff;
  glls_result_t            res_new;
  logic                    push, pop;

  assign acc_eff = e1_ok_r ? acc_rd : '0;
  assign prod    = acc_eff * param_rd[PARAM_W-1:OFF_W];

  // round to q.8 and take from the offset, 41 bits signed
  assign rsum  = {1'b0, e2_prod_r} + (PROD_W+1)'(32768);
  assign sdiff = {{(SCORE_W+1-OFF_W){e2_off_r[OFF_W-1]}}, e2_off_r}
               - {2'b00, rsum[PROD_W:16]};

  always_comb begin
    res_new.last = e2_last_r;
    res_new.idx  = CIDX_W'(e2_idx_r);
    priority if (sdiff[SCORE_W] != sdiff[SCORE_W-1]) begin
      res_new.score = sdiff[SCORE_W] ? SCORE_MIN : SCORE_MAX;
    end else begin
      res_new.score = sdiff[SCORE_W-1:0];
    end
  end

  assign push = e2_vld_r;
  assign pop  = res_valid & res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
      e2_vld_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      e1_vld_r <= iss.vld;
      e2_vld_r <= e1_vld_r;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + RES_FIFO_CW'(push) - RES_FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    e1_idx_r  <= iss_idx;
    e1_last_r <= iss.last;
    e1_ok_r   <= iss.ok;
    e2_idx_r  <= e1_idx_r;
    e2_last_r <= e1_last_r;
    e2_prod_r <= prod;
    e2_off_r  <= param_rd[OFF_W-1:0];
    if (push) begin
      fifo_r[wr_ptr_r] <= res_new;
    end
  end

  // in-flight results hold a queue slot each
  assign room = ({1'b0, cnt_r} + (RES_FIFO_CW+1)'(e1_vld_r) + (RES_FIFO_CW+1)'(e2_vld_r))
              < (RES_FIFO_CW+1)'(RES_FIFO_DEPTH);

  assign res_valid = (cnt_r != '0);
  assign res       = fifo_r[rd_ptr_r];

endmodule

>>> hw/rtl/cluster_gaussian_loglik_scorer_core.sv
// ----------------------------------------------------------------------------
// cluster_gaussian_loglik_scorer_core
// scores streamed feature values against per-cluster mean functions
// ----------------------------------------------------------------------------
// a load is written to its table as it is taken; a score feature steps through the n clusters in use,
//   one cluster per cycle through the shared square-and-accumulate pipe, then waits for its drain
// a last feature then issues one result per cluster in use; each passes the ram reads and the emit
//   registers into the result queue, then one result per cycle while the output side takes them
// throughput: one item at a time, as input is taken only while the sequencer is idle
// reset: synchronous, active low; clears control, accumulator valid bits (accumulators
//   read as zero) and sets the cluster count to 16; no clearing pass is needed
module cluster_gaussian_loglik_scorer_core
  import glls_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // cluster[3:0], feature_index[9:4], value[25:10], offset[57:26], scale[73:58], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]        in_tuser,
  input  logic                   in_tlast,
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cluster_index[3:0], score[43:4], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // cluster count register
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNW = $clog2(MAX_CLUSTERS + 1);
  localparam int MD  = MAX_CLUSTERS * MAX_FEATURES;
  localparam int MAW = (MD > 1) ? $clog2(MD) : 1;

  // input field unpacking
  logic [CL_W-1:0]  in_cl;
  logic [FI_W-1:0]  in_fi;
  logic [VAL_W-1:0] in_val;
  logic [OFF_W-1:0] in_off;
  logic [SCL_W-1:0] in_scl;
  glls_op_t         in_op;

  assign in_cl  = in_tdata[3:0];
  assign in_fi  = in_tdata[9:4];
  assign in_val = in_tdata[25:10];
  assign in_off = in_tdata[57:26];
  assign in_scl = in_tdata[73:58];
  assign in_op  = glls_op_t'(in_tuser);

  // control and item registers
  glls_state_t              state_r, state_nxt;
  logic [CNW-1:0]           cnt_r, cnt_nxt;
  logic [CNW-1:0]           n_r, n_nxt;
  logic [CFG_W-1:0]         cfg_r;
  logic signed [VAL_W-1:0]  x_r;
  logic [FI_W-1:0]          fi_r;
  logic                     last_r;
  logic [MAX_CLUSTERS-1:0]  acc_ok_r;

  logic                     in_xfer, capture, clear_ok, cnt_last, fi_ok, cl_ok;
  logic                     mean_we, param_we;
  glls_issue_t              score_iss, emit_iss;
  logic [CIW-1:0]           cnt_idx;
  logic [31:0]              n_clamp;

  // ram ports
  logic [VAL_W-1:0]         mean_rd;
  logic [PARAM_W-1:0]       param_rd;
  logic [ACC_W-1:0]         acc_rd;
  logic [MAW-1:0]           mean_waddr, mean_raddr;

  logic                     acc_wr_en;
  logic [CIW-1:0]           acc_wr_idx;
  logic [ACC_W-1:0]         acc_wr_data;
  logic                     acc_busy;
  logic                     emit_room;
  glls_result_t             res;

  assign in_xfer  = in_tvalid & in_tready;
  assign cnt_idx  = cnt_r[CIW-1:0];
  assign cnt_last = (CNW'(cnt_r + 1'b1) == n_r);
  assign fi_ok    = (32'(in_fi) < 32'(MAX_FEATURES));
  assign cl_ok    = (32'(in_cl) < 32'(MAX_CLUSTERS));

  // cluster count clamp: zero acts as one, above the array size acts as the size
  always_comb begin
    n_clamp = 32'(cfg_r);
    priority if (n_clamp == 32'd0) begin
      n_clamp = 32'd1;
    end else if (n_clamp > 32'(MAX_CLUSTERS)) begin
      n_clamp = 32'(MAX_CLUSTERS);
    end else begin
      n_clamp = 32'(cfg_r);
    end
  end

  // mean table is cluster-major, one row of features per cluster
  assign mean_waddr = MAW'(MAW'(in_cl) * MAW'(MAX_FEATURES) + MAW'(in_fi));
  assign mean_raddr = MAW'(MAW'(cnt_idx) * MAW'(MAX_FEATURES) + MAW'(fi_r));

  // sequencer: next state and issue
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    in_tready = 1'b0;
    capture   = 1'b0;
    clear_ok  = 1'b0;
    mean_we   = 1'b0;
    param_we  = 1'b0;
    score_iss = '0;
    emit_iss  = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          unique case (in_op)
            OP_LOAD_MEAN: begin
              mean_we = cl_ok & fi_ok;
            end
            OP_LOAD_PARAM: begin
              param_we = cl_ok;
            end
            OP_SCORE: begin
              capture   = 1'b1;
              n_nxt     = CNW'(n_clamp);
              cnt_nxt   = '0;
              // a feature beyond the table adds nothing but still ends the item
              state_nxt = fi_ok ? ST_SCORE : ST_DRAIN;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCORE: begin
        score_iss.vld  = 1'b1;
        score_iss.last = cnt_last;
        score_iss.ok   = acc_ok_r[cnt_idx];
        cnt_nxt        = CNW'(cnt_r + 1'b1);
        if (cnt_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // interlock: all accumulator writes land before the score pass reads them
        if (!acc_busy) begin
          cnt_nxt   = '0;
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_room) begin
          emit_iss.vld  = 1'b1;
          emit_iss.last = cnt_last;
          emit_iss.ok   = acc_ok_r[cnt_idx];
          cnt_nxt       = CNW'(cnt_r + 1'b1);
          if (cnt_last) begin
            clear_ok  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      n_r      <= '0;
      cfg_r    <= CFG_RESET;
      acc_ok_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      if (cfg_valid & cfg_ready) begin
        cfg_r <= cfg_data;
      end
      // an accumulator never written since the last clear reads as zero
      if (clear_ok) begin
        acc_ok_r <= '0;
      end else if (acc_wr_en) begin
        acc_ok_r[acc_wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      x_r    <= in_val;
      fi_r   <= in_fi;
      last_r <= in_tlast;
    end
  end

  // the user must make register writes only while idle; the block itself does not enforce this
  assign cfg_ready = 1'b1;

  // storage
  glls_ram #(.W(VAL_W), .D(MD)) u_mean_ram (
    .clk     (clk),
    .wr_en   (mean_we),
    .wr_addr (mean_waddr),
    .wr_data (in_val),
    .rd_addr (mean_raddr),
    .rd_data (mean_rd)
  );

  // offset in the low bits, scale above
  glls_ram #(.W(PARAM_W), .D(MAX_CLUSTERS)) u_param_ram (
    .clk     (clk),
    .wr_en   (param_we),
    .wr_addr (CIW'(in_cl)),
    .wr_data ({in_scl, in_off}),
    .rd_addr (cnt_idx),
    .rd_data (param_rd)
  );

  glls_ram #(.W(ACC_W), .D(MAX_CLUSTERS)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_wr_idx),
    .wr_data (acc_wr_data),
    .rd_addr (cnt_idx),
    .rd_data (acc_rd)
  );

  // datapaths
  glls_accum #(.CIW(CIW)) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .iss     (score_iss),
    .iss_idx (cnt_idx),
    .x       (x_r),
    .mean_rd (mean_rd),
    .acc_rd  (acc_rd),
    .wr_en   (acc_wr_en),
    .wr_idx  (acc_wr_idx),
    .wr_data (acc_wr_data),
    .busy    (acc_busy)
  );

  glls_emit #(.CIW(CIW)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss       (emit_iss),
    .iss_idx   (cnt_idx),
    .acc_rd    (acc_rd),
    .param_rd  (param_rd),
    .room      (emit_room),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{(OUT_TDATA_W-SCORE_W-CIDX_W){1'b0}}, res.score, res.idx};
  assign out_tlast = res.last;

`ifndef NO_ASSERTIONS
  // no accumulator write may still be in flight once results are being read out
  a_no_wr_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !acc_wr_en)
    else $error("accumulator write during result issue");

  // accumulators stand cleared after a result pass
  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ST_EMIT && state_r == ST_IDLE) |-> (acc_ok_r == '0))
    else $error("accumulators not cleared after results");

  // the final result of a run belongs to the highest cluster in use
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[CIDX_W-1:0] == CIDX_W'(n_r - 1'b1)))
    else $error("last result on wrong cluster");
`endif

endmodule

>>> dv/cluster_gaussian_loglik_scorer_core_tb.sv
// ----------------------------------------------------------------------------
// cluster_gaussian_loglik_scorer_core_tb
// self-checking bench for the per-cluster gaussian log-likelihood scorer:
// preloads the means at the scored feature positions and every offset and
// scale, walks a directed table, then runs random phases over several cluster
// counts and handshake idling patterns, checking each result transfer against
// an in-bench scoring model
// ----------------------------------------------------------------------------
module cluster_gaussian_loglik_scorer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import glls_pkg::*;

  localparam int N_CL        = MAX_CLUSTERS_DEF;
  localparam int N_FI        = MAX_FEATURES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // long enough for any non-last score feature still in flight to finish
  localparam int DRAIN_WAIT  = 48;
  localparam int HOLD_LEN    = 400;
  localparam int PHASE_ITEMS = 30;
  // feature positions that score transfers use, all preloaded for every cluster
  localparam int N_PRE       = 8;

  // op code the block does not decode
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam longint unsigned DIST_SAT = 64'h0000_003F_FFFF_FFFF;
  localparam longint          SCORE_HI = 64'sh0000_007F_FFFF_FFFF;
  localparam longint          SCORE_LO = -SCORE_HI - 64'sd1;

  // one input transfer, unpacked
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [CL_W-1:0]  cl;
    logic [FI_W-1:0]  fi;
    logic [VAL_W-1:0] val;
    logic [OFF_W-1:0] off;
    logic [SCL_W-1:0] scl;
    logic             last;
  } item_t;

  // directed row: item, repeat count, optional hand-written score for cluster 0
  typedef struct {
    item_t  it;
    int     reps;
    bit     typed;
    longint typed_score;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // cluster[3:0], feature_index[9:4], value[25:10], offset[57:26], scale[73:58], zero pad
  logic [IN_TDATA_W-1:0]  in_tdata;
  // op[1:0]
  logic [OP_W-1:0]        in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  // cluster_index[3:0], score[43:4], zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  cluster_gaussian_loglik_scorer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // scoring model state, kept in step with every accepted transfer
  logic signed [VAL_W-1:0] mean_mem [N_CL][N_FI];
  logic [OFF_W-1:0]        off_mem  [N_CL];
  logic [SCL_W-1:0]        scl_mem  [N_CL];
  longint unsigned         dist_acc [N_CL];
  logic [CFG_W-1:0]        clusters_cfg;

  // scores still owed by the block, oldest first
  glls_result_t scores_due [$];

  dir_row_t dir_tab [17];

  int fails      = 0;
  int cycle_cnt  = 0;
  int send_idle  = 0;   // percent of cycles the sender holds back
  int recv_idle  = 0;   // percent of cycles the receiver holds back
  int hold_reqs  = 0;   // bumped to ask the receiver for a long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("cluster_gaussian_loglik_scorer_core_tb: FAIL");
      $finish;
    end
  end

  // effective cluster count: zero acts as one, anything past the array size saturates
  function automatic int active_count();
    int n;
    n = clusters_cfg;
    if (n == 0) n = 1;
    if (n > N_CL) n = N_CL;
    return n;
  endfunction

  // scored feature positions, covering every one the directed table uses
  function automatic logic [FI_W-1:0] pre_fi(input int k);
    case (k)
      0:       return FI_W'(0);
      1:       return FI_W'(1);
      2:       return FI_W'(7);
      3:       return FI_W'(20);
      4:       return FI_W'(21);
      5:       return FI_W'(42);
      6:       return FI_W'(62);
      default: return FI_W'(63);
    endcase
  endfunction

  // applies one accepted transfer to the model and returns the scores it releases
  task automatic loglik_model(input item_t it, output glls_result_t res [N_CL],
                              output int nres);
    int              n;
    longint          d;
    longint unsigned acc;
    longint unsigned prod;
    longint          r;
    longint          s;
    nres = 0;
    case (it.op)
      OP_LOAD_MEAN: mean_mem[it.cl][it.fi] = it.val;
      OP_LOAD_PARAM: begin
        off_mem[it.cl] = it.off;
        scl_mem[it.cl] = it.scl;
      end
      OP_SCORE: begin
        n = active_count();
        for (int c = 0; c < n; c++) begin
          d = longint'($signed(it.val)) - longint'(mean_mem[c][it.fi]);
          if (d < 0) d = -d;
          acc = dist_acc[c] + longint'(d * d);
          dist_acc[c] = (acc > DIST_SAT) ? DIST_SAT : acc;
        end
        if (it.last) begin
          for (int c = 0; c < n; c++) begin
            // q.24 product rounded to q.8, then taken off the q24.8 offset
            prod = dist_acc[c] * longint'(scl_mem[c]);
            r    = longint'((prod + 64'd32768) >> 16);
            s    = longint'($signed(off_mem[c])) - r;
            if (s > SCORE_HI) s = SCORE_HI;
            if (s < SCORE_LO) s = SCORE_LO;
            res[c].idx   = CIDX_W'(c);
            res[c].score = s[SCORE_W-1:0];
            res[c].last  = (c == n - 1);
          end
          nres = n;
          for (int c = 0; c < N_CL; c++) dist_acc[c] = 0;
        end
      end
      default: ;
    endcase
  endtask

  // offers one item, holds it until the transfer and books the scores it owes
  task automatic put_item(input item_t it, input bit typed = 1'b0,
                          input longint typed_score = 0);
    glls_result_t res [N_CL];
    int           nres;
    int           gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, it.scl, it.off, it.val, it.fi, it.cl};
    in_tuser  <= it.op;
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    loglik_model(it, res, nres);
    // hand-written value replaces the model's for cluster 0 where the table gives one
    if (typed && nres > 0) res[0].score = typed_score[SCORE_W-1:0];
    for (int i = 0; i < nres; i++) scores_due.push_back(res[i]);
  endtask

  // value with a bias towards the q8.8 extremes
  function automatic logic [VAL_W-1:0] pick_val();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.op   = OP_W'($urandom_range(3));
    it.cl   = CL_W'($urandom);
    it.fi   = FI_W'($urandom);
    it.val  = pick_val();
    it.off  = $urandom;
    it.scl  = ($urandom_range(9) == 0) ? {SCL_W{1'b1}} : SCL_W'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  // idle block: input low, every score back, then any non-last feature has finished
  task automatic settle();
    in_tvalid <= 1'b0;
    while (scores_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_clusters(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clusters_cfg = v;
  endtask

  // mostly well-formed feature runs ending in last, mixed with table loads and noise;
  // a run left open is closed before returning so the accumulators end clear
  task automatic run_phase(input int n_items);
    item_t it;
    int    sent;
    int    len;
    int    pick;
    bit    open;
    sent = 0;
    open = 1'b0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = $urandom_range(1, 5);
        for (int k = 0; k < len; k++) begin
          it      = rand_item();
          it.op   = OP_SCORE;
          it.fi   = pre_fi($urandom_range(N_PRE - 1));
          // now and then a run is left without its last and carries into the next one
          it.last = (k == len - 1) && ($urandom_range(9) != 0);
          put_item(it);
          open = !it.last;
        end
        sent += len;
      end else if (pick < 80) begin
        it    = rand_item();
        it.op = OP_LOAD_MEAN;
        put_item(it);
        sent++;
      end else if (pick < 92) begin
        it    = rand_item();
        it.op = OP_LOAD_PARAM;
        put_item(it);
        sent++;
      end else begin
        // unused op code, ignored by the block and not counted
        it    = rand_item();
        it.op = OP_UNUSED;
        put_item(it);
      end
    end
    if (open) begin
      it      = rand_item();
      it.op   = OP_SCORE;
      it.fi   = pre_fi($urandom_range(N_PRE - 1));
      it.last = 1'b1;
      put_item(it);
    end
  endtask

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != seen) begin
        seen      = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // result check, field by field against the oldest owed score
  always @(posedge clk) begin
    glls_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (scores_due.size() == 0) begin
        $error("unexpected result: cluster_index %0d score %0d last %0b",
               out_tdata[3:0], $signed(out_tdata[43:4]), out_tlast);
        fails++;
      end else begin
        want = scores_due.pop_front();
        if (out_tdata[3:0] !== want.idx) begin
          $error("cluster_index: expected %0d, got %0d", want.idx, out_tdata[3:0]);
          fails++;
        end
        if (out_tdata[43:4] !== want.score) begin
          $error("score: expected %0d, got %0d", want.score, $signed(out_tdata[43:4]));
          fails++;
        end
        if (out_tlast !== want.last) begin
          $error("last_result: expected %0b, got %0b", want.last, out_tlast);
          fails++;
        end
      end
    end
  end

  initial begin
    item_t it;
    int    cfg_list [6];
    cfg_list = '{1, 0, 31, 16, 17, 7};

    // typed scores: scale zero leaves the offset untouched
    dir_tab = '{
      '{'{OP_LOAD_PARAM, 4'd0,  6'd0,  16'h0000, 32'h7FFF_FFFF, 16'h0000, 1'b0}, 1, 1'b0, 0},
      '{'{OP_SCORE,      4'd0,  6'd0,  16'h7FFF, 32'h0000_0000, 16'h0000, 1'b1}, 1, 1'b1,
        64'sd2147483647},
      // last on a load is ignored
      '{'{OP_LOAD_PARAM, 4'd0,  6'd63, 16'hFFFF, 32'h8000_0000, 16'h0000, 1'b1}, 1, 1'b0, 0},
      '{'{OP_SCORE,      4'd15, 6'd63, 16'h8000, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1, 1'b1,
        -64'sd2147483648},
      // unused op with every field set: no result
      '{'{OP_UNUSED,     4'd15, 6'd63, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1}, 1, 1'b0, 0},
      '{'{OP_LOAD_MEAN,  4'd15, 6'd63, 16'h7FFF, 32'h0000_0000, 16'h0000, 1'b1}, 1, 1'b0, 0},
      '{'{OP_LOAD_MEAN,  4'd0,  6'd1,  16'h7FFF, 32'h0000_0000, 16'h0000, 1'b0}, 1, 1'b0, 0},
      '{'{OP_LOAD_PARAM, 4'd15, 6'd0,  16'h0000, 32'h0000_0000, 16'hFFFF, 1'b0}, 1, 1'b0, 0},
      '{'{OP_LOAD_PARAM, 4'd0,  6'd0,  16'h0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0}, 1, 1'b0, 0},
      // largest distance, repeated past the accumulator ceiling for cluster 0
      '{'{OP_SCORE,      4'd0,  6'd1,  16'h8000, 32'h0000_0000, 16'h0000, 1'b0}, 70, 1'b0, 0},
      '{'{OP_SCORE,      4'd0,  6'd63, 16'h8000, 32'h0000_0000, 16'h0000, 1'b1}, 1, 1'b0, 0},
      // zero distance for cluster 5
      '{'{OP_LOAD_MEAN,  4'd5,  6'd20, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0}, 1, 1'b0, 0},
      '{'{OP_SCORE,      4'd0,  6'd20, 16'h0000, 32'h0000_0000, 16'h0000, 1'b1}, 1, 1'b0, 0},
      // two-feature item
      '{'{OP_SCORE,      4'd3,  6'd42, 16'h1234, 32'h0000_0000, 16'h0000, 1'b0}, 1, 1'b0, 0},
      '{'{OP_SCORE,      4'd9,  6'd21, 16'hFEDC, 32'h0000_0000, 16'h0000, 1'b1}, 1, 1'b0, 0},
      // unit scale
      '{'{OP_LOAD_PARAM, 4'd0,  6'd0,  16'h0000, 32'h0000_0000, 16'h0100, 1'b0}, 1, 1'b0, 0},
      '{'{OP_SCORE,      4'd0,  6'd7,  16'h0100, 32'h0000_0000, 16'h0000, 1'b1}, 1, 1'b0, 0}
    };

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_LOAD_MEAN;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    clusters_cfg = CFG_RESET;
    for (int c = 0; c < N_CL; c++) dist_acc[c] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // fill the means at every scored feature position, and every offset and scale,
    // so no score reads an unwritten entry
    for (int c = 0; c < N_CL; c++) begin
      for (int f = 0; f < N_PRE; f++) begin
        it    = rand_item();
        it.op = OP_LOAD_MEAN;
        it.cl = CL_W'(c);
        it.fi = pre_fi(f);
        put_item(it);
      end
      it    = rand_item();
      it.op = OP_LOAD_PARAM;
      it.cl = CL_W'(c);
      put_item(it);
    end

    // directed rows at the reset cluster count
    send_idle = 28;
    recv_idle = 70;
    for (int i = 0; i < $size(dir_tab); i++) begin
      for (int k = 0; k < dir_tab[i].reps; k++)
        put_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].typed_score);
    end

    // random phases: sender-light, receiver-light, then free running with one long stall
    for (int p = 0; p < 6; p++) begin
      settle();
      set_clusters(CFG_W'(cfg_list[p]));
      send_idle = (p < 2) ? 28 : (p < 4) ? 70 : 0;
      recv_idle = (p < 2) ? 70 : (p < 4) ? 28 : 0;
      if (p == 4) hold_reqs++;
      run_phase(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    while (scores_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0 && scores_due.size() == 0) begin
      $display("cluster_gaussian_loglik_scorer_core_tb: PASS");
    end else begin
      $display("cluster_gaussian_loglik_scorer_core_tb: FAIL");
    end
    $finish;
  end

endmodule
